// File: hw/rtl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared types and constants for the region metadata table.
// ----------------------------------------------------------------------------
package rmt_pkg;

   localparam int NUM_SLOTS_DEF = 64;

   localparam int KEY_W    = 64;
   localparam int TAG_W    = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   // opcodes
   localparam logic [OP_W-1:0] OP_INIT = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH = 2'd1;
   localparam logic [OP_W-1:0] OP_POP  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STS_PERMANENT = 3'd3;
   localparam logic [STATUS_W-1:0] STS_BAD_INIT  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_TAG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_TAG    = 1'd1;

   localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             keep;
   } rec_type;

   localparam rec_type EMPTY_REC = '{key: EMPTY_KEY, tag: '0, keep: 1'b0};

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [KEY_W-1:0]    key;
      logic [TAG_W-1:0]    tag;
      logic                keep;
   } rsp_type;

endpackage

// File: hw/rtl/rmt_rsp_reg.sv
// ----------------------------------------------------------------------------
// rmt_rsp_reg
// Output register for result transactions; frees the core as soon as a
// result is parked here.
// ----------------------------------------------------------------------------
module rmt_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   output logic             load_ready,
   input  rmt_pkg::rsp_type load_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmt_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   rmt_pkg::rsp_type data_ff;

   assign load_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hw/rtl/region_metadata_table.sv
// ----------------------------------------------------------------------------
// region_metadata_table
// Table of NUM_SLOTS region records (key, tag, keep) held in one
// synchronous RAM; init / push / pop / read by linear scan from slot 0.
// ----------------------------------------------------------------------------
//
//  channel | ports        | handshake        | moves
//  --------+--------------+------------------+-------------------------------
//  request | req_*        | valid / ready    | opcode, key, tag, keep flag
//  result  | rsp_*        | valid / ready    | status, slot, key, tag, keep
//  config  | csr_*        | write enable     | default_tag, self_tag
//
//  One request transaction is in work at a time. A push/pop/read scans the
//  RAM one slot per cycle (read data registered) until a slot matches or
//  the last slot misses, then hands its result to the output register.
//  Init with key 0 sweeps every slot, one write per cycle. After reset a
//  clearing pass empties the RAM; req_ready stays low meanwhile, csr
//  writes are taken. A stalled result sits in the output register and
//  does not block acceptance of the next request.
// ----------------------------------------------------------------------------
module region_metadata_table #(
   parameter int NUM_SLOTS = rmt_pkg::NUM_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rmt_pkg::OP_W-1:0]        req_opcode,
   input  logic [rmt_pkg::KEY_W-1:0]       req_entry_key,
   input  logic [rmt_pkg::TAG_W-1:0]       req_tag_handle,
   input  logic                            req_keep_flag,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rmt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rmt_pkg::SLOT_W-1:0]      rsp_out_slot,
   output logic [rmt_pkg::KEY_W-1:0]       rsp_out_key,
   output logic [rmt_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic                            rsp_out_keep,
   // configuration writes
   input  logic                            csr_wr_en,
   input  logic [rmt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rmt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   // FSM codes
   localparam logic [1:0] FSM_CLEAR  = 2'd0;  // sweep writes (reset or init)
   localparam logic [1:0] FSM_IDLE   = 2'd1;
   localparam logic [1:0] FSM_SCAN   = 2'd2;
   localparam logic [1:0] FSM_FINISH = 2'd3;  // hand result to output reg

   logic [1:0]                   state_ff, state_in;

   // latched request
   logic [rmt_pkg::OP_W-1:0]     op_ff, op_in;
   logic [rmt_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [rmt_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic                         keep_ff, keep_in;

   // config registers
   logic [rmt_pkg::TAG_W-1:0]    default_tag_ff, default_tag_in;
   logic [rmt_pkg::TAG_W-1:0]    self_tag_ff, self_tag_in;

   // sweep / scan control
   logic                         init_pend_ff, init_pend_in;
   logic [IDX_W-1:0]             sweep_idx_ff, sweep_idx_in;
   logic [IDX_W-1:0]             issue_idx_ff, issue_idx_in;
   logic                         issue_done_ff, issue_done_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;

   // pending result
   rmt_pkg::rsp_type             res_ff, res_in;

   // record RAM
   rmt_pkg::rec_type             mem [NUM_SLOTS];
   rmt_pkg::rec_type             rd_data_ff;
   logic                         mem_we;
   logic [IDX_W-1:0]             mem_waddr;
   rmt_pkg::rec_type             mem_wdata;

   logic [rmt_pkg::KEY_W-1:0]    match_key;
   logic                         hit;
   logic                         last;
   logic [IDX_W+rmt_pkg::SLOT_W-1:0] slot_ext;
   logic [rmt_pkg::SLOT_W-1:0]   hit_slot;
   logic                         ld_valid;
   logic                         ld_ready;
   rmt_pkg::rsp_type             rsp_data;

   // --- RAM: one write port, one registered read port ----------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[issue_idx_ff];
   end

   // Push scans for the empty marker, pop/read for the request key.
   assign match_key = (op_ff == rmt_pkg::OP_PUSH) ? rmt_pkg::EMPTY_KEY : key_ff;
   assign hit       = rd_vld_ff && (rd_data_ff.key == match_key);
   assign last      = rd_vld_ff && (rd_idx_ff == LAST_IDX);

   // out_slot carries the low six bits of the index (zero-extended if narrower)
   assign slot_ext  = {{rmt_pkg::SLOT_W{1'b0}}, rd_idx_ff};
   assign hit_slot  = slot_ext[rmt_pkg::SLOT_W-1:0];

   assign req_ready = (state_ff == FSM_IDLE);

   // --- config writes --------------------------------------------------------
   always_comb begin
      default_tag_in = default_tag_ff;
      self_tag_in    = self_tag_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rmt_pkg::CSR_DEFAULT_TAG: default_tag_in = csr_wdata;
            rmt_pkg::CSR_SELF_TAG:    self_tag_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // --- control --------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      keep_in       = keep_ff;
      init_pend_in  = init_pend_ff;
      sweep_idx_in  = sweep_idx_ff;
      issue_idx_in  = issue_idx_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = issue_idx_ff;
      res_in        = res_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_idx_ff;
      mem_wdata     = rmt_pkg::EMPTY_REC;
      ld_valid      = 1'b0;

      unique case (state_ff)
         FSM_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_idx_ff;
            if (init_pend_ff && (sweep_idx_ff == '0)) begin
               // self record in slot 0
               mem_wdata.key  = '0;
               mem_wdata.tag  = self_tag_ff;
               mem_wdata.keep = 1'b1;
            end
            sweep_idx_in = sweep_idx_ff + 1'b1;
            if (sweep_idx_ff == LAST_IDX) begin
               state_in     = init_pend_ff ? FSM_FINISH : FSM_IDLE;
               init_pend_in = 1'b0;
            end
         end

         FSM_IDLE: begin
            if (req_valid) begin
               op_in         = req_opcode;
               key_in        = req_entry_key;
               tag_in        = req_tag_handle;
               keep_in       = req_keep_flag;
               issue_idx_in  = '0;
               issue_done_in = 1'b0;
               res_in        = '0;
               if (req_opcode == rmt_pkg::OP_INIT) begin
                  if (req_entry_key != '0) begin
                     res_in.status = rmt_pkg::STS_BAD_INIT;
                     state_in      = FSM_FINISH;
                  end else begin
                     res_in.status = rmt_pkg::STS_OK;
                     init_pend_in  = 1'b1;
                     sweep_idx_in  = '0;
                     state_in      = FSM_CLEAR;
                  end
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end

         FSM_SCAN: begin
            // issue one read per cycle, compare the one returning
            if (!issue_done_ff) begin
               issue_idx_in = issue_idx_ff + 1'b1;
               rd_vld_in    = 1'b1;
               if (issue_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
            if (hit) begin
               rd_vld_in     = 1'b0;
               state_in      = FSM_FINISH;
               res_in.slot   = hit_slot;
               res_in.status = rmt_pkg::STS_OK;
               case (op_ff)
                  rmt_pkg::OP_PUSH: begin
                     mem_we         = 1'b1;
                     mem_wdata.key  = key_ff;
                     mem_wdata.tag  = (tag_ff != '0) ? tag_ff : default_tag_ff;
                     mem_wdata.keep = keep_ff;
                  end
                  rmt_pkg::OP_POP: begin
                     if (rd_data_ff.keep) begin
                        res_in.status = rmt_pkg::STS_PERMANENT;
                     end else begin
                        mem_we = 1'b1;  // write back an empty record
                     end
                  end
                  default: begin
                     res_in.key  = rd_data_ff.key;
                     res_in.tag  = rd_data_ff.tag;
                     res_in.keep = rd_data_ff.keep;
                  end
               endcase
            end else if (last) begin
               rd_vld_in     = 1'b0;
               state_in      = FSM_FINISH;
               res_in.status = (op_ff == rmt_pkg::OP_PUSH) ? rmt_pkg::STS_FULL
                                                           : rmt_pkg::STS_NOT_FOUND;
            end
         end

         FSM_FINISH: begin
            ld_valid = 1'b1;
            if (ld_ready) begin
               state_in = FSM_IDLE;
            end
         end

         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_CLEAR;
         init_pend_ff   <= 1'b0;
         sweep_idx_ff   <= '0;
         issue_idx_ff   <= '0;
         issue_done_ff  <= 1'b0;
         rd_vld_ff      <= 1'b0;
         default_tag_ff <= '0;
         self_tag_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         init_pend_ff   <= init_pend_in;
         sweep_idx_ff   <= sweep_idx_in;
         issue_idx_ff   <= issue_idx_in;
         issue_done_ff  <= issue_done_in;
         rd_vld_ff      <= rd_vld_in;
         default_tag_ff <= default_tag_in;
         self_tag_ff    <= self_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      tag_ff    <= tag_in;
      keep_ff   <= keep_in;
      rd_idx_ff <= rd_idx_in;
      res_ff    <= res_in;
   end

   // --- output register ------------------------------------------------------
   rmt_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (ld_valid),
      .load_ready (ld_ready),
      .load_data  (res_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_status   = rsp_data.status;
   assign rsp_out_slot = rsp_data.slot;
   assign rsp_out_key  = rsp_data.key;
   assign rsp_out_tag  = rsp_data.tag;
   assign rsp_out_keep = rsp_data.keep;

endmodule

// File: hw/rtl/rmt_checker.sv
// ----------------------------------------------------------------------------
// rmt_checker
// Port-level checks for the region metadata table, bound to the top level.
// ----------------------------------------------------------------------------
module rmt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rmt_pkg::STATUS_W-1:0]    rsp_status,
   input logic [rmt_pkg::SLOT_W-1:0]      rsp_out_slot,
   input logic [rmt_pkg::KEY_W-1:0]       rsp_out_key,
   input logic [rmt_pkg::TAG_W-1:0]       rsp_out_tag,
   input logic                            rsp_out_keep
);

   // transactions accepted but not yet answered
   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + 2'(req_acc) - 2'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no result without an outstanding request
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result without request");

   // at most one in work plus one parked result
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many outstanding transactions");

   // results with a status other than ok carry zero key, tag and keep
   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rmt_pkg::STS_OK) |->
         (rsp_out_key == '0 && rsp_out_tag == '0 && rsp_out_keep == 1'b0))
      else $error("record data on failed result");

   // stalled result holds its status, slot and key
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_out_slot)
          && $stable(rsp_out_key)))
      else $error("result changed while stalled");

endmodule

bind region_metadata_table rmt_checker u_rmt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_out_slot  (rsp_out_slot),
   .rsp_out_key   (rsp_out_key),
   .rsp_out_tag   (rsp_out_tag),
   .rsp_out_keep  (rsp_out_keep)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks region_metadata_table against a cycle-free shadow of the record
// table: a directed table of corner cases first, then random phases under
// different tag settings, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;

   import rmt_pkg::*;

   localparam int NUM_SLOTS      = NUM_SLOTS_DEF;
   localparam int DIR_ROWS       = 25;
   localparam int PHASE_ITEMS    = 200;
   localparam int POOL_SIZE      = 16;
   // many times the worst gap between transactions, which comes from a miss
   // scan, the clearing pass or a receiver stall
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             keep;
   } req_item_type;

   // one row of the directed table; want is only used when fixed is set
   typedef struct packed {
      req_item_type item;
      logic         fixed;
      rsp_type      want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_opcode     = '0;
   logic [KEY_W-1:0]      req_entry_key  = '0;
   logic [TAG_W-1:0]      req_tag_handle = '0;
   logic                  req_keep_flag  = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_out_slot;
   logic [KEY_W-1:0]      rsp_out_key;
   logic [TAG_W-1:0]      rsp_out_tag;
   logic                  rsp_out_keep;

   logic                  csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // shadow copy of the record table and of the two tag registers
   rec_type               region_tbl [NUM_SLOTS];
   logic [TAG_W-1:0]      dflt_tag_cfg;
   logic [TAG_W-1:0]      self_tag_cfg;

   // responses owed by the DUT, oldest first
   rsp_type               table_results_q [$];

   logic [KEY_W-1:0]      key_pool [POOL_SIZE];
   dir_row_type           directed_rows [DIR_ROWS];

   int unsigned           burst_left;
   int unsigned           mismatches;
   int unsigned           idle_cycles;
   int unsigned           op_count [4];
   int unsigned           status_count [8];

   // receiver stall pattern state
   int unsigned           stall_mode;
   int unsigned           stall_left;
   logic [2:0]            stall_tick;
   rsp_type               want_rsp;

   region_metadata_table #(
      .NUM_SLOTS(NUM_SLOTS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_entry_key (req_entry_key),
      .req_tag_handle(req_tag_handle),
      .req_keep_flag (req_keep_flag),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_slot  (rsp_out_slot),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_keep  (rsp_out_keep),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow table
   // ------------------------------------------------------------------------

   // lowest slot holding key, NUM_SLOTS on a miss; an all-ones key simply
   // finds the first empty slot
   function automatic int first_slot(logic [KEY_W-1:0] key);
      int i;
      for (i = 0; i < NUM_SLOTS; i++)
         if (region_tbl[i].key == key)
            return i;
      return NUM_SLOTS;
   endfunction

   // applies one request to the shadow table and returns its response
   function automatic rsp_type apply_region_op(req_item_type item);
      rsp_type r;
      int      hit;
      int      i;
      r = '0;
      case (item.op)
         OP_INIT: begin
            if (item.key != '0) begin
               r.status = STS_BAD_INIT;   // table left alone
            end else begin
               for (i = 0; i < NUM_SLOTS; i++)
                  region_tbl[i] = EMPTY_REC;
               region_tbl[0] = '{key: '0, tag: self_tag_cfg, keep: 1'b1};
            end
         end
         OP_PUSH: begin
            hit = first_slot(EMPTY_KEY);
            if (hit == NUM_SLOTS) begin
               r.status = STS_FULL;
            end else begin
               // null tag falls back to the default tag register
               region_tbl[hit] = '{key: item.key,
                                   tag: (item.tag != '0) ? item.tag : dflt_tag_cfg,
                                   keep: item.keep};
               r.slot = hit[SLOT_W-1:0];
            end
         end
         OP_POP: begin
            hit = first_slot(item.key);
            if (hit == NUM_SLOTS) begin
               r.status = STS_NOT_FOUND;
            end else if (region_tbl[hit].keep) begin
               r.status = STS_PERMANENT;
               r.slot   = hit[SLOT_W-1:0];
            end else begin
               region_tbl[hit] = EMPTY_REC;
               r.slot = hit[SLOT_W-1:0];
            end
         end
         default: begin
            hit = first_slot(item.key);
            if (hit == NUM_SLOTS) begin
               r.status = STS_NOT_FOUND;
            end else begin
               r.slot = hit[SLOT_W-1:0];
               r.key  = region_tbl[hit].key;
               r.tag  = region_tbl[hit].tag;
               r.keep = region_tbl[hit].keep;
            end
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // random request; keys mostly come from a small pool so pops and reads
   // hit, with some zero, all-ones and fully random keys mixed in
   function automatic req_item_type rand_item(int unsigned push_w, int unsigned pop_w,
                                              int unsigned init_w);
      req_item_type item;
      int unsigned pick;
      int unsigned kp;
      pick = $urandom_range(0, 99);
      kp   = $urandom_range(0, 99);
      if (pick < init_w)
         item.op = OP_INIT;
      else if (pick < init_w + push_w)
         item.op = OP_PUSH;
      else if (pick < init_w + push_w + pop_w)
         item.op = OP_POP;
      else
         item.op = OP_READ;
      if (kp < 68)
         item.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (kp < 78)
         item.key = '0;
      else if (kp < 84)
         item.key = EMPTY_KEY;
      else
         item.key = {$urandom, $urandom};
      // most inits are good ones, the rest carry a random (bad) key
      if (item.op == OP_INIT && kp < 85)
         item.key = '0;
      item.tag  = ($urandom_range(0, 3) == 0) ? '0 : TAG_W'($urandom);
      item.keep = ($urandom_range(0, 4) == 0);
      return item;
   endfunction

   // write both tag registers back to back; only called with no request in work
   task automatic write_tags(input logic [TAG_W-1:0] dflt, input logic [TAG_W-1:0] slf);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEFAULT_TAG;
      csr_wdata <= dflt;
      @(posedge clock);
      dflt_tag_cfg = dflt;
      csr_index <= CSR_SELF_TAG;
      csr_wdata <= slf;
      @(posedge clock);
      self_tag_cfg = slf;
      csr_wr_en <= 1'b0;
   endtask

   // drives one request transaction and returns the shadow's response at
   // acceptance; requests go out in bursts with random gaps in between
   task automatic send_req(input req_item_type item, output rsp_type pred);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_opcode     <= item.op;
      req_entry_key  <= item.key;
      req_tag_handle <= item.tag;
      req_keep_flag  <= item.keep;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      op_count[item.op]++;
      pred = apply_region_op(item);
   endtask

   task automatic drain_results();
      while (table_results_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int           n;
      int           ph;
      rsp_type      pred;
      req_item_type item;
      logic [TAG_W-1:0] ph_dflt;
      logic [TAG_W-1:0] ph_self;
      int unsigned  ph_push;
      int unsigned  ph_pop;
      int unsigned  ph_init;

      for (n = 0; n < NUM_SLOTS; n++)
         region_tbl[n] = EMPTY_REC;
      dflt_tag_cfg = '0;
      self_tag_cfg = '0;
      burst_left   = 0;

      // Directed rows, run with default tag all ones and self tag zero.
      // The table starts empty, so the first rows act on it before any init.
      directed_rows = '{
         // read before init: nothing there
         '{'{OP_READ, 64'h0, 32'h0, 1'b0}, 1'b1, '{STS_NOT_FOUND, 6'd0, 64'h0, 32'h0, 1'b0}},
         '{'{OP_POP,  64'h5, 32'h0, 1'b0}, 1'b1, '{STS_NOT_FOUND, 6'd0, 64'h0, 32'h0, 1'b0}},
         // all-ones key matches the first empty slot
         '{'{OP_READ, EMPTY_KEY, 32'h0, 1'b0}, 1'b1,
           '{STS_OK, 6'd0, EMPTY_KEY, 32'h0, 1'b0}},
         // pushing the empty marker leaves the slot counting as empty
         '{'{OP_PUSH, EMPTY_KEY, 32'h0, 1'b0}, 1'b1, '{STS_OK, 6'd0, 64'h0, 32'h0, 1'b0}},
         // bad init keys
         '{'{OP_INIT, 64'h1, 32'h0, 1'b0}, 1'b1, '{STS_BAD_INIT, 6'd0, 64'h0, 32'h0, 1'b0}},
         '{'{OP_INIT, EMPTY_KEY, 32'hFFFF_FFFF, 1'b1}, 1'b1,
           '{STS_BAD_INIT, 6'd0, 64'h0, 32'h0, 1'b0}},
         '{'{OP_INIT, 64'h8000_0000_0000_0000, 32'h0, 1'b0}, 1'b1,
           '{STS_BAD_INIT, 6'd0, 64'h0, 32'h0, 1'b0}},
         // good init, then the self record is permanent
         '{'{OP_INIT, 64'h0, 32'h0, 1'b0}, 1'b1, '{STS_OK, 6'd0, 64'h0, 32'h0, 1'b0}},
         '{'{OP_READ, 64'h0, 32'h0, 1'b0}, 1'b1, '{STS_OK, 6'd0, 64'h0, 32'h0, 1'b1}},
         '{'{OP_POP,  64'h0, 32'h0, 1'b0}, 1'b1, '{STS_PERMANENT, 6'd0, 64'h0, 32'h0, 1'b0}},
         '{'{OP_PUSH, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0}, 1'b1,
           '{STS_OK, 6'd1, 64'h0, 32'h0, 1'b0}},
         '{'{OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFE, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
         '{'{OP_READ, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0}, 1'b0, '0},
         '{'{OP_READ, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0, 1'b0}, 1'b0, '0},
         '{'{OP_POP,  64'hFFFF_FFFF_FFFF_FFFE, 32'h0, 1'b0}, 1'b0, '0},
         // duplicate key: reads and pops act on the lowest slot
         '{'{OP_PUSH, 64'h0, 32'h5555_5555, 1'b0}, 1'b0, '0},
         '{'{OP_READ, 64'h0, 32'h0, 1'b0}, 1'b0, '0},
         '{'{OP_PUSH, EMPTY_KEY, 32'hAAAA_AAAA, 1'b1}, 1'b0, '0},
         '{'{OP_READ, EMPTY_KEY, 32'h0, 1'b0}, 1'b0, '0},
         '{'{OP_POP,  EMPTY_KEY, 32'h0, 1'b0}, 1'b0, '0},
         '{'{OP_PUSH, 64'h5555_5555_5555_5555, 32'h1, 1'b0}, 1'b0, '0},
         '{'{OP_POP,  64'h0123_4567_89AB_CDEF, 32'h0, 1'b0}, 1'b0, '0},
         '{'{OP_READ, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0}, 1'b0, '0},
         '{'{OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0001, 1'b0}, 1'b0, '0},
         '{'{OP_POP,  64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 1'b0}, 1'b0, '0}
      };

      // synchronous reset; csr writes are taken during the clearing pass
      // that follows, requests wait on req_ready
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_tags(32'hFFFF_FFFF, 32'h0);

      for (n = 0; n < DIR_ROWS; n++) begin
         send_req(directed_rows[n].item, pred);
         table_results_q.push_back(directed_rows[n].fixed ? directed_rows[n].want : pred);
      end

      // Random phases. Each starts idle with new tag settings and a fresh
      // key pool. Phase 0 is push heavy without init so the table fills up;
      // phase 2 leans on pops to drain it again.
      for (ph = 0; ph < 4; ph++) begin
         req_valid <= 1'b0;
         drain_results();
         case (ph)
            0: begin
               ph_dflt = 32'h0;          ph_self = 32'hFFFF_FFFF;
               ph_push = 75; ph_pop = 10; ph_init = 0;
            end
            1: begin
               ph_dflt = $urandom;       ph_self = $urandom;
               ph_push = 40; ph_pop = 30; ph_init = 4;
            end
            2: begin
               ph_dflt = 32'h0000_0001;  ph_self = 32'h8000_0000;
               ph_push = 15; ph_pop = 55; ph_init = 3;
            end
            default: begin
               ph_dflt = $urandom;       ph_self = $urandom;
               ph_push = 45; ph_pop = 25; ph_init = 6;
            end
         endcase
         for (n = 0; n < POOL_SIZE; n++)
            key_pool[n] = {$urandom, $urandom};
         write_tags(ph_dflt, ph_self);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            item = rand_item(ph_push, ph_pop, ph_init);
            send_req(item, pred);
            table_results_q.push_back(pred);
         end
      end

      // wait for the last responses, then keep the clock running to catch
      // anything extra coming out
      req_valid <= 1'b0;
      drain_results();
      repeat (NUM_SLOTS + 8) @(posedge clock);

      $display("covered %0d init, %0d push, %0d pop, %0d read transactions",
               op_count[OP_INIT], op_count[OP_PUSH], op_count[OP_POP], op_count[OP_READ]);
      $display("responses: %0d ok, %0d full, %0d not found, %0d permanent, %0d bad init",
               status_count[STS_OK], status_count[STS_FULL], status_count[STS_NOT_FOUND],
               status_count[STS_PERMANENT], status_count[STS_BAD_INIT]);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatching responses", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: stall pattern and checking
   // ------------------------------------------------------------------------
   // The mode is redrawn at random from: always ready, coin flip, one cycle
   // in eight, and mostly ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_mode <= 0;
         stall_left <= 0;
         stall_tick <= '0;
      end else begin
         stall_tick <= stall_tick + 3'd1;
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= (stall_tick == 3'd0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase

         // one response transaction: compare against the oldest owed one
         if (rsp_valid && rsp_ready) begin
            status_count[rsp_status]++;
            if (table_results_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: unexpected response status %0d slot %0d",
                           $realtime, rsp_status, rsp_out_slot);
            end else begin
               want_rsp = table_results_q.pop_front();
               if (rsp_status !== want_rsp.status || rsp_out_slot !== want_rsp.slot ||
                   rsp_out_key !== want_rsp.key || rsp_out_tag !== want_rsp.tag ||
                   rsp_out_keep !== want_rsp.keep) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%t: response mismatch", $realtime);
                     $display("   expected sts %0d slot %0d key %h tag %h keep %b",
                              want_rsp.status, want_rsp.slot, want_rsp.key,
                              want_rsp.tag, want_rsp.keep);
                     $display("   actual   sts %0d slot %0d key %h tag %h keep %b",
                              rsp_status, rsp_out_slot, rsp_out_key,
                              rsp_out_tag, rsp_out_keep);
                  end
               end
            end
         end
      end
   end

   // watchdog: too long with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d responses owed",
                  idle_cycles, table_results_q.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: files.f
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_rsp_reg.sv
hw/rtl/region_metadata_table.sv
hw/rtl/rmt_checker.sv
verif/testbench.sv
